### sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  // Storage geometry.
  localparam int unsigned DEPTH_C = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH_C);
  localparam int unsigned CNT_W   = $clog2(DEPTH_C + 1);

  // Field widths.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 6;

  // Operation codes carried by each request.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Request to the shared index step unit.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             dec;
  } idx_req_t;

endpackage

### sv/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/deq_idx_unit.sv
// Shared circular index step unit: moves an index one slot forward or back.
`timescale 1ns / 1ps

module deq_idx_unit (
  input  deq_pkg::idx_req_t              req_i,
  output logic [deq_pkg::IDX_W-1:0]      idx_o
);

  localparam logic [deq_pkg::IDX_W-1:0] LastIdx = deq_pkg::IDX_W'(deq_pkg::DEPTH_C - 1);

  // Wrap at both ends of the store.
  always_comb begin
    if (req_i.dec) begin
      idx_o = (req_i.idx == '0) ? LastIdx : req_i.idx - deq_pkg::IDX_W'(1);
    end else begin
      idx_o = (req_i.idx == LastIdx) ? '0 : req_i.idx + deq_pkg::IDX_W'(1);
    end
  end

endmodule

### sv/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one request: an opcode
//   and a signed value. Opcodes push at the front or rear, pop from the front
//   or rear, or list every stored value from front to rear.
//   The output channel (out_valid_o / out_ready_i) returns results with data,
//   status, occupancy and a last flag on the final result of each request.
//   A request is accepted in ST_IDLE, then passes through ST_EXEC and ST_OUT,
//   which loads its result into the output register. Push, pop and unused
//   opcodes make one such pass; a list makes one pass per stored value, or
//   one when the queue is empty. One circular index step unit is shared by
//   every pointer update, and the store is one RAM with a registered read.
//   in_ready_o is high only while no request is in progress.
//   Reset empties the queue (front, rear and count go to zero); the store
//   itself is not cleared and needs no clearing pass.
//   When the receiver stalls, the result is held in the output register and
//   the sequencer waits before producing the next one.
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [deq_pkg::OP_W-1:0]      opcode_i,
  input  logic signed [deq_pkg::DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [deq_pkg::DATA_W-1:0] data_o,
  output logic [deq_pkg::STAT_W-1:0]    status_o,
  output logic [deq_pkg::OCC_W-1:0]     occupancy_o,
  output logic                          last_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [deq_pkg::IDX_W-1:0]  front_q, front_d;
  logic [deq_pkg::IDX_W-1:0]  rear_q, rear_d;
  logic [deq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [deq_pkg::IDX_W-1:0]  ptr_q, ptr_d;
  logic [deq_pkg::CNT_W-1:0]  left_q, left_d;

  logic [deq_pkg::OP_W-1:0]   op_q;
  logic [deq_pkg::DATA_W-1:0] val_q;

  deq_pkg::status_e           pstat_q, pstat_d;
  logic                       plast_q, plast_d;
  logic                       psel_q, psel_d;

  logic                       out_valid_q;
  logic [deq_pkg::DATA_W-1:0] data_q;
  deq_pkg::status_e           stat_q;
  logic [deq_pkg::OCC_W-1:0]  occ_q;
  logic                       last_q;

  deq_pkg::idx_req_t          idx_req;
  logic [deq_pkg::IDX_W-1:0]  idx_res;

  logic                       ram_we, ram_re;
  logic [deq_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [deq_pkg::DATA_W-1:0] ram_rdata;

  logic in_fire, out_load, is_full, is_empty;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign is_full    = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH_C));
  assign is_empty   = (count_q == '0);

  deq_idx_unit u_idx (
    .req_i (idx_req),
    .idx_o (idx_res)
  );

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::DEPTH_C)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: execute one step of the request, then hand the result over.
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    rear_d    = rear_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    left_d    = left_q;
    pstat_d   = pstat_q;
    plast_d   = plast_q;
    psel_d    = psel_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = front_q;
    ram_raddr = front_q;
    idx_req   = '{idx: front_q, dec: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ptr_d   = front_q;
          left_d  = count_q;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        pstat_d = deq_pkg::STAT_OK;
        plast_d = 1'b1;
        psel_d  = 1'b0;
        state_d = ST_OUT;
        unique case (op_q)
          deq_pkg::OP_PUSH_FRONT: begin
            idx_req = '{idx: front_q, dec: 1'b1};
            if (is_full) begin
              pstat_d = deq_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = idx_res;
              front_d   = idx_res;
              count_d   = count_q + deq_pkg::CNT_W'(1);
            end
          end
          deq_pkg::OP_PUSH_REAR: begin
            idx_req = '{idx: rear_q, dec: 1'b0};
            if (is_full) begin
              pstat_d = deq_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = rear_q;
              rear_d    = idx_res;
              count_d   = count_q + deq_pkg::CNT_W'(1);
            end
          end
          deq_pkg::OP_POP_FRONT: begin
            idx_req = '{idx: front_q, dec: 1'b0};
            if (is_empty) begin
              pstat_d = deq_pkg::STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = front_q;
              front_d   = idx_res;
              count_d   = count_q - deq_pkg::CNT_W'(1);
              psel_d    = 1'b1;
            end
          end
          deq_pkg::OP_POP_REAR: begin
            idx_req = '{idx: rear_q, dec: 1'b1};
            if (is_empty) begin
              pstat_d = deq_pkg::STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = idx_res;
              rear_d    = idx_res;
              count_d   = count_q - deq_pkg::CNT_W'(1);
              psel_d    = 1'b1;
            end
          end
          deq_pkg::OP_LIST: begin
            idx_req = '{idx: ptr_q, dec: 1'b0};
            if (left_q == '0) begin
              pstat_d = deq_pkg::STAT_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = ptr_q;
              ptr_d     = idx_res;
              left_d    = left_q - deq_pkg::CNT_W'(1);
              plast_d   = (left_q == deq_pkg::CNT_W'(1));
              psel_d    = 1'b1;
            end
          end
          default: begin
            // Unused opcodes leave the queue untouched.
          end
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = plast_q ? ST_IDLE : ST_EXEC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, walk state and pending result.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= opcode_i;
      val_q <= $unsigned(value_i);
    end
    ptr_q   <= ptr_d;
    left_q  <= left_d;
    pstat_q <= pstat_d;
    plast_q <= plast_d;
    psel_q  <= psel_d;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      data_q <= psel_q ? ram_rdata : '0;
      stat_q <= pstat_q;
      occ_q  <= deq_pkg::OCC_W'(count_q);
      last_q <= plast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = $signed(data_q);
  assign status_o    = stat_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;

endmodule

### sv/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module deq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [deq_pkg::DATA_W-1:0] data_o,
  input logic [deq_pkg::STAT_W-1:0]        status_o,
  input logic                              last_o
);

  // A request is never followed by another in the next cycle.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted in two consecutive cycles");

  // A failed operation reports zero data.
  a_fail_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != deq_pkg::STAT_OK) |-> data_o == '0)
    else $error("failed operation reported nonzero data");

  // A failed operation is always the final result of its request.
  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != deq_pkg::STAT_OK) |-> last_o)
    else $error("failed operation not marked last");

  // Only defined status codes are reported.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == deq_pkg::STAT_OK) || (status_o == deq_pkg::STAT_EMPTY) ||
                    (status_o == deq_pkg::STAT_FULL))
    else $error("undefined status code");

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_o      (data_o),
  .status_o    (status_o),
  .last_o      (last_o)
);
